>>> design/tree_ancestor_path_query_unit_defines.svh
// Assertion macros used by the checker file
`ifndef TREE_ANCESTOR_PATH_QUERY_UNIT_DEFINES_SVH
`define TREE_ANCESTOR_PATH_QUERY_UNIT_DEFINES_SVH
// Assert that a implies b on the same edge
`define TAPQ_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("tapq check failed");
// Assert that a implies b on the next edge
`define TAPQ_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("tapq check failed");
`endif

>>> design/tapq_pkg.sv
// ---------------------------------------------------------------------------
// tapq_pkg
// Shared types and constants of the tree ancestor path query unit.
// ---------------------------------------------------------------------------
package tapq_pkg;
  localparam int NodeW  = 12;
  localparam int Levels = 13;
  localparam int LvlW   = 4;
  localparam int Nodes  = 4096;
  localparam int AddrW  = LvlW + NodeW;
  localparam logic [NodeW-1:0] DepthMax = 12'hfff;

  typedef logic [NodeW-1:0]  node_t;
  typedef logic [LvlW-1:0]   lvl_t;
  typedef logic [Levels-1:0] steps_t;

  localparam lvl_t LvlTop = lvl_t'(Levels - 1);

  localparam logic ReqInsert = 1'b0;
  localparam logic ReqQuery  = 1'b1;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,      // latch request
    OP_RD_DA,     // read depth of a
    OP_RD_DB,     // capture depth of a, read depth of b
    OP_INS_D,     // write depth and level 0 of insert
    OP_INS_RD,    // read anc[lvl-1][w]
    OP_INS_WR,    // write anc[lvl][a] from read data
    OP_ORDER,     // capture depth of b, order u/v by depth
    OP_LIFT_RD,   // read anc[lvl][v]
    OP_LIFT_WR,   // step v, read its depth
    OP_LIFT_DEP,  // capture depth of the new v
    OP_CMP_RDU,   // read anc[lvl][u]
    OP_CMP_RDV,   // hold anc[lvl][u], read anc[lvl][v]
    OP_CMP_WR,    // step both where the ancestors differ
    OP_LCA_SELF,  // u is the common ancestor: read its depth
    OP_LCA_RD,    // read parent of u
    OP_LCA_WR,    // read depth of the parent of u
    OP_DL,        // capture depth of common ancestor
    OP_PLAN,      // choose walk
    OP_WALK_RD,   // read anc[lvl][w]
    OP_WALK_WR    // take walk data
  } op_t;

  typedef struct packed {
    op_t  op;
    lvl_t lvl;
  } cmd_t;

  typedef struct packed {
    logic   is_query;
    logic   eq_uv;
    logic   dist_le;   // answer is b
    logic   lift_take; // current lifting level applies
    logic   walk_take; // current walk level applies
  } sts_t;
endpackage

>>> design/tapq_if.sv
// ---------------------------------------------------------------------------
// tapq_req_if / tapq_rsp_if
// Valid/ready channels for requests and results.
// ---------------------------------------------------------------------------
interface tapq_req_if import tapq_pkg::*; (input logic clk);
  logic  valid;
  logic  ready;
  logic  req_type;
  node_t node_a;
  node_t node_b;
  node_t steps_c;
  modport source (output valid, req_type, node_a, node_b, steps_c, input ready);
  modport sink   (input valid, req_type, node_a, node_b, steps_c, output ready);
endinterface

interface tapq_rsp_if import tapq_pkg::*; (input logic clk);
  logic  valid;
  logic  ready;
  node_t result_node;
  modport source (output valid, result_node, input ready);
  modport sink   (input valid, result_node, output ready);
endinterface

>>> design/tapq_datapath.sv
// ---------------------------------------------------------------------------
// tapq_datapath
// Ancestor and depth memories with the walk registers.
// ---------------------------------------------------------------------------
module tapq_datapath import tapq_pkg::*; (
  input  logic  clk,
  input  cmd_t  cmd,
  input  logic  in_req_type,
  input  node_t in_node_a,
  input  node_t in_node_b,
  input  node_t in_steps_c,
  output sts_t  sts,
  output node_t result
);
  logic [NodeW-1:0] anc_mem [Levels*Nodes];
  logic [NodeW-1:0] dep_mem [Nodes];

  node_t  a_r, b_r, c_r, u_r, v_r, w_r, su_r, du_r, dv_r, da_r, db_r, dl_r;
  steps_t dd_r;
  logic   kind_r;

  // memory addressing
  logic             anc_we;
  logic [AddrW-1:0] anc_wa, anc_ra;
  node_t            anc_wd, dep_ra, dep_wd;
  logic             dep_we;
  node_t            anc_q, dep_q;

  function automatic logic [AddrW-1:0] aaddr(lvl_t l, node_t n);
    return {l, n};
  endfunction

  always_comb begin
    anc_we = 1'b0;
    anc_wa = aaddr(cmd.lvl, a_r);
    anc_wd = anc_q;
    anc_ra = aaddr(cmd.lvl, w_r);
    dep_we = 1'b0;
    dep_wd = '0;
    dep_ra = a_r;
    unique case (cmd.op)
      OP_RD_DA: dep_ra = a_r;
      OP_RD_DB: dep_ra = b_r;
      OP_INS_D: begin
        anc_we = 1'b1;
        anc_wa = aaddr(lvl_t'(0), a_r);
        anc_wd = b_r;
        dep_we = 1'b1;
        dep_wd = (a_r == b_r) ? '0 : ((dep_q == DepthMax) ? DepthMax : dep_q + 1'b1);
      end
      OP_INS_RD: anc_ra = aaddr(cmd.lvl - lvl_t'(1), w_r);
      OP_INS_WR: anc_we = 1'b1;
      OP_LIFT_RD: anc_ra = aaddr(cmd.lvl, v_r);
      OP_LIFT_WR: dep_ra = anc_q;
      OP_CMP_RDU, OP_LCA_RD: anc_ra = aaddr(cmd.lvl, u_r);
      OP_CMP_RDV: anc_ra = aaddr(cmd.lvl, v_r);
      OP_LCA_SELF: dep_ra = u_r;
      OP_LCA_WR: dep_ra = anc_q;
      default: ;
    endcase
  end

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    if (anc_we) anc_mem[anc_wa] <= anc_wd;
    anc_q <= anc_mem[anc_ra];
  end

  always_ff @(posedge clk) begin
    if (dep_we) dep_mem[a_r] <= dep_wd;
    dep_q <= dep_mem[dep_ra];
  end

  // path length and upward leg, signed
  logic signed [NodeW+2:0] span_s, up_s, c_s, rest_s;
  logic dist_le, from_b;
  assign span_s = $signed({3'b0, da_r}) + $signed({3'b0, db_r}) - $signed({2'b0, dl_r, 1'b0});
  assign up_s   = $signed({3'b0, da_r}) - $signed({3'b0, dl_r});
  assign c_s    = $signed({3'b0, c_r});
  assign rest_s = span_s - c_s;
  assign dist_le = span_s <= c_s;
  assign from_b  = up_s < c_s;

  // walk registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        kind_r <= in_req_type;
        a_r <= in_node_a; b_r <= in_node_b; c_r <= in_steps_c;
      end
      OP_RD_DB: da_r <= dep_q;
      OP_INS_D: w_r <= b_r;  // level 1 reads anc[0][b]
      OP_INS_WR: w_r <= anc_q;
      OP_ORDER: begin
        db_r <= dep_q;
        if (da_r > dep_q) begin
          u_r <= b_r; v_r <= a_r; du_r <= dep_q; dv_r <= da_r;
        end else begin
          u_r <= a_r; v_r <= b_r; du_r <= da_r; dv_r <= dep_q;
        end
      end
      OP_LIFT_WR: v_r <= anc_q;
      OP_LIFT_DEP: dv_r <= dep_q;
      OP_CMP_RDV: su_r <= anc_q;
      OP_CMP_WR: if (su_r != anc_q) begin u_r <= su_r; v_r <= anc_q; end
      OP_DL: dl_r <= dep_q;
      OP_PLAN: begin
        if (dist_le) w_r <= b_r;
        else if (from_b) begin w_r <= b_r; dd_r <= rest_s[Levels-1:0]; end
        else begin w_r <= a_r; dd_r <= {1'b0, c_r}; end
      end
      OP_WALK_WR: w_r <= anc_q;
      default: ;
    endcase
  end

  always_comb begin
    sts.is_query  = kind_r;
    sts.eq_uv     = (u_r == v_r);
    sts.dist_le   = dist_le;
    sts.lift_take = ({1'b0, du_r} + (steps_t'(1) << cmd.lvl)) <= {1'b0, dv_r};
    sts.walk_take = dd_r[cmd.lvl];
  end

  assign result = w_r;
endmodule

>>> design/tapq_ctrl.sv
// ---------------------------------------------------------------------------
// tapq_ctrl
// Sequencer for insert and query requests.
// ---------------------------------------------------------------------------
module tapq_ctrl import tapq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_DEP_A, S_DEP_B, S_INS_D, S_INS_RD, S_INS_WR,
    S_ORDER, S_LIFT, S_LIFT_WR, S_LIFT_DEP, S_EQ,
    S_CMP_RDU, S_CMP_RDV, S_CMP_WR, S_LCA_RD, S_LCA_WR,
    S_DL, S_PLAN, S_WALK, S_WALK_WR
  } state_t;

  state_t state_r;
  lvl_t   lvl_r;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.lvl = lvl_r;
    cmd.op  = OP_NONE;
    unique case (state_r)
      S_IDLE:     cmd.op = (in_valid && in_ready) ? OP_LOAD : OP_NONE;
      S_DEP_A:    cmd.op = OP_RD_DA;
      S_DEP_B:    cmd.op = OP_RD_DB;
      S_INS_D:    cmd.op = OP_INS_D;
      S_INS_RD:   cmd.op = OP_INS_RD;
      S_INS_WR:   cmd.op = OP_INS_WR;
      S_ORDER:    cmd.op = OP_ORDER;
      S_LIFT:     cmd.op = OP_LIFT_RD;
      S_LIFT_WR:  cmd.op = OP_LIFT_WR;
      S_LIFT_DEP: cmd.op = OP_LIFT_DEP;
      S_EQ:       cmd.op = OP_LCA_SELF;
      S_CMP_RDU:  cmd.op = OP_CMP_RDU;
      S_CMP_RDV:  cmd.op = OP_CMP_RDV;
      S_CMP_WR:   cmd.op = OP_CMP_WR;
      S_LCA_RD:   cmd.op = OP_LCA_RD;
      S_LCA_WR:   cmd.op = OP_LCA_WR;
      S_DL:       cmd.op = OP_DL;
      S_PLAN:     cmd.op = OP_PLAN;
      S_WALK:     cmd.op = OP_WALK_RD;
      S_WALK_WR:  cmd.op = OP_WALK_WR;
      default:    cmd.op = OP_NONE;
    endcase
  end

  // advance through the phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; lvl_r <= '0; out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_valid_r) begin
            if (out_ready) out_valid_r <= 1'b0;
          end else if (in_valid) begin
            state_r <= S_DEP_A;
          end
        end
        S_DEP_A: state_r <= S_DEP_B;
        S_DEP_B: state_r <= sts.is_query ? S_ORDER : S_INS_D;
        S_INS_D: begin lvl_r <= lvl_t'(1); state_r <= S_INS_RD; end
        S_INS_RD: state_r <= S_INS_WR;
        S_INS_WR: begin
          if (lvl_r == LvlTop) state_r <= S_IDLE;
          else begin lvl_r <= lvl_r + lvl_t'(1); state_r <= S_INS_RD; end
        end
        S_ORDER: begin lvl_r <= LvlTop; state_r <= S_LIFT; end
        S_LIFT: begin
          if (sts.lift_take) state_r <= S_LIFT_WR;
          else if (lvl_r == '0) state_r <= S_EQ;
          else lvl_r <= lvl_r - lvl_t'(1);
        end
        S_LIFT_WR: state_r <= S_LIFT_DEP;
        S_LIFT_DEP: begin
          if (lvl_r == '0) state_r <= S_EQ;
          else begin lvl_r <= lvl_r - lvl_t'(1); state_r <= S_LIFT; end
        end
        S_EQ: begin
          if (sts.eq_uv) state_r <= S_DL;
          else begin lvl_r <= LvlTop; state_r <= S_CMP_RDU; end
        end
        S_CMP_RDU: state_r <= S_CMP_RDV;
        S_CMP_RDV: state_r <= S_CMP_WR;
        S_CMP_WR: begin
          if (lvl_r == '0) state_r <= S_LCA_RD;
          else begin lvl_r <= lvl_r - lvl_t'(1); state_r <= S_CMP_RDU; end
        end
        S_LCA_RD: state_r <= S_LCA_WR;
        S_LCA_WR: state_r <= S_DL;
        S_DL: state_r <= S_PLAN;
        S_PLAN: begin
          if (sts.dist_le) begin out_valid_r <= 1'b1; state_r <= S_IDLE; end
          else begin lvl_r <= LvlTop; state_r <= S_WALK; end
        end
        S_WALK: begin
          if (sts.walk_take) state_r <= S_WALK_WR;
          else if (lvl_r == '0) begin out_valid_r <= 1'b1; state_r <= S_IDLE; end
          else lvl_r <= lvl_r - lvl_t'(1);
        end
        S_WALK_WR: begin
          if (lvl_r == '0) begin out_valid_r <= 1'b1; state_r <= S_IDLE; end
          else begin lvl_r <= lvl_r - lvl_t'(1); state_r <= S_WALK; end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/tree_ancestor_path_query_unit.sv
// ---------------------------------------------------------------------------
// tree_ancestor_path_query_unit
// Binary-lifting ancestor store with insert and path-walk requests.
// ---------------------------------------------------------------------------
// One request at a time. An insert, once accepted, first reads the parent's depth
// and writes level 0, then does a read and a write of the ancestor memory for each
// of the 12 upper levels. A query reads and orders the depths, lifts the deeper
// node level by level (also reading the new ancestor's depth where the level is
// taken), sees whether the nodes already meet, climbs both nodes level by level
// to the common ancestor when they do not, reads that ancestor's depth and
// chooses the walk, and walks level by level when the answer is not the end node.
// The answer is held until taken; the next request is accepted in the cycle after
// that. Memories are not cleared; only inserted nodes may be read.
module tree_ancestor_path_query_unit import tapq_pkg::*; (
  input logic clk,
  input logic rst_n,
  tapq_req_if.sink   in_ch,
  tapq_rsp_if.source out_ch
);
  cmd_t  cmd;
  sts_t  sts;
  node_t result;

  tapq_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  tapq_datapath u_dp (
    .clk, .cmd,
    .in_req_type(in_ch.req_type), .in_node_a(in_ch.node_a),
    .in_node_b(in_ch.node_b), .in_steps_c(in_ch.steps_c),
    .sts, .result
  );

  // the walk register holds the answer while the result is pending
  assign out_ch.result_node = result;
endmodule

>>> design/tapq_checker.sv
// ---------------------------------------------------------------------------
// tapq_checker
// Port-level checks of the path query unit.
// ---------------------------------------------------------------------------
`include "tree_ancestor_path_query_unit_defines.svh"
module tapq_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  `TAPQ_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
  `TAPQ_ASSERT_IMPL(a_no_take_while_pending, clk, rst_n, out_valid, !in_ready)
  `TAPQ_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind tree_ancestor_path_query_unit tapq_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
